// ===== sv/melody_step_sequencer_assert.svh =====
`ifndef MELODY_STEP_SEQUENCER_ASSERT_SVH
`define MELODY_STEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("melody_step_sequencer: check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MSS_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("melody_step_sequencer: check failed");

`endif

// ===== sv/mss_pkg.sv =====
`default_nettype none

package mss_pkg;

    localparam int MSS_MAX_STEPS     = 256;
    localparam int MSS_NOTE_TOTAL    = 96;
    localparam int MSS_LOWEST_OCTAVE = 1;

    localparam logic [10:0] MSS_DRAIN_UNIT    = 11'd480;
    localparam logic [9:0]  MSS_TEMPO_DEFAULT = 10'd120;
    localparam logic [7:0]  MSS_NOTE_REST     = 8'h80;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_START       = 3'd1,
        CMD_STOP        = 3'd2,
        CMD_PREVIEW     = 3'd3,
        CMD_PREVIEW_OFF = 3'd4,
        CMD_WRITE_STEP  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_MELODY  = 2'd1,
        MODE_PREVIEW = 2'd2
    } mode_t;

    localparam logic [1:0] CFG_TEMPO  = 2'd0;
    localparam logic [1:0] CFG_LENGTH = 2'd1;
    localparam logic [1:0] CFG_LOOP   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN,
        S_LOAD,
        S_READ,
        S_PITCH,
        S_DONE
    } state_t;

    // Octave-4 timer divider for each pitch class.
    function automatic logic [12:0] base_divider(input logic [3:0] pc);
        logic [12:0] d;
        case (pc)
            4'd0:    d = 13'd4238;
            4'd1:    d = 13'd4000;
            4'd2:    d = 13'd3776;
            4'd3:    d = 13'd3564;
            4'd4:    d = 13'd3364;
            4'd5:    d = 13'd3175;
            4'd6:    d = 13'd2997;
            4'd7:    d = 13'd2829;
            4'd8:    d = 13'd2670;
            4'd9:    d = 13'd2520;
            4'd10:   d = 13'd2379;
            4'd11:   d = 13'd2245;
            default: d = 13'd2245;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mss_pitch.sv =====
`default_nettype none

module mss_pitch (
    input  wire logic [6:0]  note,
    output logic      [15:0] divider
);

    logic [14:0] prod;
    logic [3:0]  octave_idx;
    logic [6:0]  oct_base;
    logic [3:0]  semitone;
    logic [4:0]  octave;
    logic [12:0] base;
    logic [3:0]  shift;
    logic [16:0] scaled;

    // Dividing by 12 through a reciprocal: 171 / 2048 is exact for notes below 128.
    assign prod        = 15'(note) * 15'd171;
    assign octave_idx  = prod[14:11];
    assign oct_base    = 7'(octave_idx) * 7'd12;
    assign semitone    = 4'(note - oct_base);
    assign octave      = 5'(octave_idx) + 5'(mss_pkg::MSS_LOWEST_OCTAVE);
    assign base        = mss_pkg::base_divider(semitone);

    always_comb
    begin
        shift  = 4'd0;
        scaled = 17'(base);
        if (octave < 5'd4)
        begin
            shift  = 4'(5'd4 - octave);
            scaled = 17'(base) << shift;
        end
        else if (octave > 5'd4)
        begin
            shift  = 4'(octave - 5'd4);
            scaled = (17'(base) + (17'd1 << (shift - 4'd1))) >> shift;
            if (scaled == 17'd0)
            begin
                scaled = 17'd1;
            end
        end
    end

    assign divider = scaled[15:0];

endmodule

`default_nettype wire

// ===== sv/melody_step_sequencer.sv =====
// Tone sequencer for a square-wave speaker timer.
// Requests enter on the req channel (cmd and its note and step fields) and each one
// produces exactly one result on the res channel: the divider in effect, gate state,
// play mode, the sounding note and the current step position.
// A request is taken when req_valid is high and req_stall is low; a result is taken
// when res_valid is high and res_stall is low. The result register parts the two
// sides, so a new request is taken while an older result still waits.
// One request is worked on at a time. Stop, preview off, write step, spare codes and
// an idle tick go through the execute state straight to the done state; a preview adds
// the pitch state, and a start adds load, memory read and pitch. A melody tick drains
// one sixteenth per drain step and on each step change loads, reads the memory and
// computes the divider; a tempo below 1024 drains three sixteenths at most. The next
// request is taken in the cycle after the result is loaded.
// The user writes registers through cfg_we, cfg_index and cfg_data only while no request
// is in flight; the block has no check for it. Reset leaves the sequencer idle, silent,
// at step zero, tempo 120, an empty melody and looping off; the melody memory holds no
// defined contents. While the receiver stalls, the finished result stays on the outputs
// and at most one further request is taken and held until the result register frees up.
`default_nettype none

`include "melody_step_sequencer_assert.svh"

module melody_step_sequencer #(
    parameter int MAX_STEPS = mss_pkg::MSS_MAX_STEPS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [6:0]  req_note,
    input  wire logic        req_rest,
    input  wire logic [7:0]  step_address,
    input  wire logic [7:0]  step_sixteenths,

    output logic             res_valid,
    input  wire logic        res_stall,
    output logic      [15:0] divider,
    output logic             gate_on,
    output logic      [1:0]  play_mode,
    output logic      [6:0]  sounding_note,
    output logic             sounding_rest,
    output logic      [8:0]  step_position
);

    localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    // Control state.
    mss_pkg::state_t state_reg, state_next;
    mss_pkg::mode_t  mode_reg, mode_next;
    logic [8:0]      position_reg, position_next;
    logic [10:0]     acc_reg, acc_next;
    logic [7:0]      left_reg, left_next;
    logic [7:0]      note_reg, note_next;
    logic [15:0]     divider_reg, divider_next;
    logic [9:0]      tempo_reg;
    logic [8:0]      length_reg;
    logic            loop_reg;
    logic            res_valid_reg, res_valid_next;

    // Request fields held for the duration of the work.
    mss_pkg::cmd_t   cmd_reg;
    logic [6:0]      note_in_reg;
    logic            rest_in_reg;
    logic [7:0]      addr_in_reg;
    logic [7:0]      len_in_reg;

    // Result register.
    logic [15:0]     res_divider_reg;
    logic [1:0]      res_mode_reg;
    logic [7:0]      res_note_reg;
    logic [8:0]      res_position_reg;

    // Melody memory.
    logic [15:0]       mem [MAX_STEPS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    logic [8:0]  used_steps;
    logic [10:0] acc_sum;
    logic [7:0]  left_dec;
    logic [15:0] pitch_div;
    logic        take_req;
    logic        load_res;

    assign used_steps = (32'(length_reg) < MAX_STEPS) ? length_reg : 9'(MAX_STEPS);
    assign acc_sum    = acc_reg + 11'(tempo_reg);
    assign left_dec   = (left_reg != 8'd0) ? (left_reg - 8'd1) : 8'd0;
    assign take_req   = req_valid && !req_stall;

    mss_pitch u_pitch (
        .note    (note_reg[6:0]),
        .divider (pitch_div)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        position_next  = position_reg;
        acc_next       = acc_reg;
        left_next      = left_reg;
        note_next      = note_reg;
        divider_next   = divider_reg;
        res_valid_next = res_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(addr_in_reg);
        mem_wdata      = {len_in_reg, rest_in_reg, note_in_reg};
        mem_re         = 1'b0;
        mem_raddr      = ADDR_W'(position_reg);
        load_res       = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            mss_pkg::S_IDLE:
            begin
                if (take_req)
                begin
                    state_next = mss_pkg::S_EXEC;
                end
            end

            mss_pkg::S_EXEC:
            begin
                state_next = mss_pkg::S_DONE;
                case (cmd_reg)
                    mss_pkg::CMD_TICK:
                    begin
                        if (mode_reg == mss_pkg::MODE_MELODY)
                        begin
                            acc_next   = acc_sum;
                            state_next = mss_pkg::S_DRAIN;
                        end
                    end
                    mss_pkg::CMD_START:
                    begin
                        if (used_steps != 9'd0)
                        begin
                            mode_next     = mss_pkg::MODE_MELODY;
                            position_next = 9'd0;
                            acc_next      = 11'd0;
                            state_next    = mss_pkg::S_LOAD;
                        end
                    end
                    mss_pkg::CMD_STOP:
                    begin
                        mode_next    = mss_pkg::MODE_IDLE;
                        acc_next     = 11'd0;
                        left_next    = 8'd0;
                        divider_next = 16'd0;
                        note_next    = mss_pkg::MSS_NOTE_REST;
                    end
                    mss_pkg::CMD_PREVIEW:
                    begin
                        mode_next  = mss_pkg::MODE_PREVIEW;
                        left_next  = 8'd0;
                        state_next = mss_pkg::S_PITCH;
                        if (rest_in_reg || !(32'(note_in_reg) < mss_pkg::MSS_NOTE_TOTAL))
                        begin
                            note_next = mss_pkg::MSS_NOTE_REST;
                        end
                        else
                        begin
                            note_next = {1'b0, note_in_reg};
                        end
                    end
                    mss_pkg::CMD_PREVIEW_OFF:
                    begin
                        if (mode_reg == mss_pkg::MODE_PREVIEW)
                        begin
                            mode_next    = mss_pkg::MODE_IDLE;
                            acc_next     = 11'd0;
                            left_next    = 8'd0;
                            divider_next = 16'd0;
                            note_next    = mss_pkg::MSS_NOTE_REST;
                        end
                    end
                    mss_pkg::CMD_WRITE_STEP:
                    begin
                        mem_we = (32'(addr_in_reg) < MAX_STEPS);
                    end
                    default:
                    begin
                    end
                endcase
            end

            mss_pkg::S_DRAIN:
            begin
                if (acc_reg >= mss_pkg::MSS_DRAIN_UNIT)
                begin
                    acc_next  = acc_reg - mss_pkg::MSS_DRAIN_UNIT;
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        position_next = position_reg + 9'd1;
                        state_next    = mss_pkg::S_LOAD;
                    end
                end
                else
                begin
                    state_next = mss_pkg::S_DONE;
                end
            end

            mss_pkg::S_LOAD:
            begin
                if (used_steps == 9'd0 || (position_reg >= used_steps && !loop_reg))
                begin
                    mode_next    = mss_pkg::MODE_IDLE;
                    acc_next     = 11'd0;
                    left_next    = 8'd0;
                    divider_next = 16'd0;
                    note_next    = mss_pkg::MSS_NOTE_REST;
                    state_next   = mss_pkg::S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = mss_pkg::S_READ;
                    if (position_reg >= used_steps)
                    begin
                        position_next = 9'd0;
                        mem_raddr     = '0;
                    end
                end
            end

            mss_pkg::S_READ:
            begin
                left_next  = (mem_rdata[15:8] != 8'd0) ? mem_rdata[15:8] : 8'd1;
                state_next = mss_pkg::S_PITCH;
                if (mem_rdata[7] || !(32'(mem_rdata[6:0]) < mss_pkg::MSS_NOTE_TOTAL))
                begin
                    note_next = mss_pkg::MSS_NOTE_REST;
                end
                else
                begin
                    note_next = {1'b0, mem_rdata[6:0]};
                end
            end

            mss_pkg::S_PITCH:
            begin
                divider_next = note_reg[7] ? 16'd0 : pitch_div;
                state_next   = (cmd_reg == mss_pkg::CMD_TICK) ? mss_pkg::S_DRAIN
                                                              : mss_pkg::S_DONE;
            end

            mss_pkg::S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    load_res       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = mss_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::S_IDLE;
            mode_reg      <= mss_pkg::MODE_IDLE;
            position_reg  <= 9'd0;
            acc_reg       <= 11'd0;
            left_reg      <= 8'd0;
            note_reg      <= mss_pkg::MSS_NOTE_REST;
            divider_reg   <= 16'd0;
            res_valid_reg <= 1'b0;
            tempo_reg     <= mss_pkg::MSS_TEMPO_DEFAULT;
            length_reg    <= 9'd0;
            loop_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            position_reg  <= position_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            note_reg      <= note_next;
            divider_reg   <= divider_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mss_pkg::CFG_TEMPO:
                    begin
                        tempo_reg <= (cfg_data == 10'd0) ? mss_pkg::MSS_TEMPO_DEFAULT
                                                         : cfg_data;
                    end
                    mss_pkg::CFG_LENGTH:
                    begin
                        length_reg <= cfg_data[8:0];
                    end
                    mss_pkg::CFG_LOOP:
                    begin
                        loop_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Request fields and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            cmd_reg     <= mss_pkg::cmd_t'(cmd);
            note_in_reg <= req_note;
            rest_in_reg <= req_rest;
            addr_in_reg <= step_address;
            len_in_reg  <= step_sixteenths;
        end
        if (load_res)
        begin
            res_divider_reg  <= divider_reg;
            res_mode_reg     <= mode_reg;
            res_note_reg     <= note_reg;
            res_position_reg <= position_reg;
        end
    end

    // Only one request is in flight, so a write and a read of the same entry never overlap.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    assign req_stall     = (state_reg != mss_pkg::S_IDLE);
    assign res_valid     = res_valid_reg;
    assign divider       = res_divider_reg;
    assign gate_on       = (res_divider_reg != 16'd0);
    assign play_mode     = res_mode_reg;
    assign sounding_note = res_note_reg[7] ? 7'd0 : res_note_reg[6:0];
    assign sounding_rest = res_note_reg[7];
    assign step_position = res_position_reg;

    // A sounding note always carries a nonzero divider and a rest never does.
    `MSS_ASSERT_IMP(a_gate_matches_note, clk, rst_n, res_valid, gate_on != sounding_rest)
    // An idle sequencer is silent.
    `MSS_ASSERT_IMP(a_idle_silent, clk, rst_n,
        res_valid && play_mode == mss_pkg::MODE_IDLE, divider == 16'd0)
    // Read data is consumed in the cycle right after the memory read.
    `MSS_ASSERT_NXT(a_read_then_use, clk, rst_n, mem_re, state_reg == mss_pkg::S_READ)

endmodule

`default_nettype wire
